// File: rtl/core/utf8d_pkg.sv
// shared types and constants for the utf-8 stream decoder
`default_nettype none

package utf8d_pkg;

	localparam int CP_W = 21;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_TRUNC   = 2'd2
	} status_t;

	// byte class boundaries
	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] CONT_MAX  = 8'hBF;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MAX = 8'hF7;

	// payload masks
	localparam logic [7:0] LEAD2_MASK = 8'h1F;
	localparam logic [7:0] LEAD3_MASK = 8'h0F;
	localparam logic [7:0] LEAD4_MASK = 8'h07;
	localparam logic [7:0] CONT_MASK  = 8'h3F;

	// one decoded result from the decode stage
	typedef struct packed {
		logic               emit;
		logic [CP_W-1:0]    code_point;
		status_t            status;
		logic               end_of_string;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/core/utf8_stream_decoder_unit.sv
// top level of the utf-8 stream decoder: input register, decode, result register
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in      | sink      | in_valid / in_ready  | data_byte[7:0], string_end
//  out     | source    | out_valid / out_ready| code_point[20:0], status[1:0],
//          |           |                      | end_of_string
//
// one byte per cycle sustained while out_ready is high; an accepted byte is held in
// the input register, and its result then in the result register
// the decode between the two registers is a shift-or into a 21-bit accumulator
// reset clears the sequence state, the discard flag and both valid flags
// when out_ready is low the result register holds and the input register
// keeps one byte, so in_ready drops only when both are full
// bytes that yield no result (continuations, discarded bytes) still pass
// through the input register but never occupy the result register
`default_nettype none

module utf8_stream_decoder_unit
	import utf8d_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      data_byte,
	input  wire logic            string_end,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [CP_W-1:0]      code_point,
	output logic [1:0]           status,
	output logic                 end_of_string
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// result register
	logic            out_valid_q;
	logic [CP_W-1:0] code_point_q;
	status_t         status_q;
	logic            eos_q;

	logic    advance;
	result_t result;

	// the decode stage moves when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			eos_s1  <= string_end;
		end
	end

	utf8d_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (byte_s1),
		.string_end (eos_s1),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result.emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.emit) begin
			code_point_q <= result.code_point;
			status_q     <= result.status;
			eos_q        <= result.end_of_string;
		end
	end

	assign out_valid     = out_valid_q;
	assign code_point    = code_point_q;
	assign status        = status_q;
	assign end_of_string = eos_q;

	// error results always carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> code_point == '0)
		else $error("error transaction with nonzero code point");

	// a truncation can only be reported at the end of a string
	a_trunc_eos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_TRUNC |-> end_of_string)
		else $error("truncation reported before end of string");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STATUS_OK || status == STATUS_INVALID ||
			status == STATUS_TRUNC))
		else $error("undefined status code");

	// a stalled result register must hold its transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(status))
		else $error("result changed while stalled");

endmodule

`default_nettype wire

// File: rtl/core/utf8d_decode.sv
// sequence state and combinational decode of one registered byte
`default_nettype none

module utf8d_decode
	import utf8d_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire logic       string_end,
	output result_t         result
);

	logic [1:0]      remaining_q;
	logic [CP_W-1:0] partial_q;
	logic            discarding_q;

	logic [1:0]      remaining_d;
	logic [CP_W-1:0] partial_d;
	logic            discarding_d;
	logic [CP_W-1:0] shifted;
	logic [1:0]      rem_dec;
	logic [7:0]      masked;

	always_comb begin
		shifted  = {partial_q[CP_W-7:0], data_byte[5:0] & CONT_MASK[5:0]};
		rem_dec  = 2'(remaining_q - 2'd1);
		masked   = 8'h00;

		remaining_d  = remaining_q;
		partial_d    = partial_q;
		discarding_d = discarding_q;

		result.emit          = 1'b0;
		result.code_point    = '0;
		result.status        = STATUS_OK;
		result.end_of_string = string_end;

		if (discarding_q) begin
			// drop bytes until the string closes
			if (string_end) begin
				remaining_d  = 2'd0;
				partial_d    = '0;
				discarding_d = 1'b0;
			end
		end else if (remaining_q != 2'd0) begin
			partial_d   = shifted;
			remaining_d = rem_dec;
			if (rem_dec == 2'd0) begin
				result.emit       = 1'b1;
				result.code_point = shifted;
				partial_d         = '0;
			end else if (string_end) begin
				result.emit   = 1'b1;
				result.status = STATUS_TRUNC;
				partial_d     = '0;
				remaining_d   = 2'd0;
			end
		end else if (data_byte <= ASCII_MAX) begin
			result.emit       = 1'b1;
			result.code_point = {{(CP_W-8){1'b0}}, data_byte};
		end else if (data_byte <= CONT_MAX || data_byte > LEAD4_MAX) begin
			// stray continuation or out-of-range lead
			result.emit   = 1'b1;
			result.status = STATUS_INVALID;
			partial_d     = '0;
			remaining_d   = 2'd0;
			discarding_d  = !string_end;
		end else begin
			if (data_byte <= LEAD2_MAX) begin
				masked      = data_byte & LEAD2_MASK;
				remaining_d = 2'd1;
			end else if (data_byte <= LEAD3_MAX) begin
				masked      = data_byte & LEAD3_MASK;
				remaining_d = 2'd2;
			end else begin
				masked      = data_byte & LEAD4_MASK;
				remaining_d = 2'd3;
			end
			partial_d = {{(CP_W-8){1'b0}}, masked};
			if (string_end) begin
				result.emit   = 1'b1;
				result.status = STATUS_TRUNC;
				partial_d     = '0;
				remaining_d   = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q  <= 2'd0;
			partial_q    <= '0;
			discarding_q <= 1'b0;
		end else if (step) begin
			remaining_q  <= remaining_d;
			partial_q    <= partial_d;
			discarding_q <= discarding_d;
		end
	end

endmodule

`default_nettype wire
